// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master transaction engine.
// Used by i2cm_seq and i2c_master_transaction_engine_top; depends on nothing.
`timescale 1ns / 1ps

package i2cm_pkg;

    // Width of the write and read byte counters.
    localparam int COUNT_BITS = 8;

    typedef logic [COUNT_BITS-1:0] t_count;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_HALF_PERIOD = 1'b0,
        CFG_ACK_POLL    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_poll_limit;
    } t_cfg;

    typedef struct packed {
        logic       sda_in;
        logic       req_start;
        logic [6:0] dev_addr;
        logic [7:0] write_count;
        logic [7:0] read_count;
        logic       keep_bus;
        logic [7:0] tx_byte;
    } t_in;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       tx_take;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_last;
        logic       done_res;
        logic       failed;
        logic       busy_res;
    } t_out;

endpackage

// ===== src/i2cm_seq.sv =====
// Bus sequencer of the I2C master: phase machine, timers, shifters and the result register.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  i2cm_pkg::t_in  i_item,
    input  i2cm_pkg::t_cfg i_cfg,
    output i2cm_pkg::t_out o_res
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_START_C   = 4'd3,
        PH_TX_LOW    = 4'd4,
        PH_TX_HIGH   = 4'd5,
        PH_ACK_LOW   = 4'd6,
        PH_ACK_HIGH  = 4'd7,
        PH_RS_A      = 4'd8,
        PH_RX_LOW    = 4'd9,
        PH_RX_HIGH   = 4'd10,
        PH_MACK_LOW  = 4'd11,
        PH_MACK_HIGH = 4'd12,
        PH_STOP_A    = 4'd13,
        PH_STOP_B    = 4'd14,
        PH_STOP_C    = 4'd15
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [15:0]      r_tick, n_tick;
    logic [3:0]       r_bit_index, n_bit_index;
    i2cm_pkg::t_count r_bytes_left, n_bytes_left;
    i2cm_pkg::t_count r_reads_left, n_reads_left;
    logic [7:0]       r_shift, n_shift;
    logic [7:0]       r_poll, n_poll;
    logic [6:0]       r_addr, n_addr;
    logic             r_keep, n_keep;
    logic             r_in_read, n_in_read;
    logic             r_fail, n_fail;
    logic             r_bus_held, n_bus_held;
    i2cm_pkg::t_out   r_res, n_res;

    logic [15:0] w_half;
    logic [16:0] w_tick_inc;
    logic        w_expired;
    logic [15:0] w_tick_next;
    logic [3:0]  w_bit_inc;
    logic [7:0]  w_poll_inc;
    logic [7:0]  w_rx_shift;
    logic        w_last_read;

    // Half-period timer: a zero setting behaves as one tick.
    assign w_half      = (i_cfg.half_period_ticks == 16'd0) ? 16'd1 : i_cfg.half_period_ticks;
    assign w_tick_inc  = {1'b0, r_tick} + 17'd1;
    assign w_expired   = w_tick_inc >= {1'b0, w_half};
    assign w_tick_next = w_expired ? 16'd0 : w_tick_inc[15:0];
    assign w_bit_inc   = r_bit_index + 4'd1;
    assign w_poll_inc  = r_poll + 8'd1;
    assign w_rx_shift  = {r_shift[6:0], i_item.sda_in};

    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_bit_index  = r_bit_index;
        n_bytes_left = r_bytes_left;
        n_reads_left = r_reads_left;
        n_shift      = r_shift;
        n_poll       = r_poll;
        n_addr       = r_addr;
        n_keep       = r_keep;
        n_in_read    = r_in_read;
        n_fail       = r_fail;
        n_bus_held   = r_bus_held;
        n_res        = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_item.req_start) begin
                    n_addr       = i_item.dev_addr;
                    n_bytes_left = i2cm_pkg::t_count'(i_item.write_count);
                    n_reads_left = i2cm_pkg::t_count'(i_item.read_count);
                    n_keep       = i_item.keep_bus;
                    n_in_read    = 1'b0;
                    n_fail       = 1'b0;
                    n_tick       = 16'd0;
                    // A held bus starts over with a repeated start.
                    n_phase      = r_bus_held ? PH_RS_A : PH_START_A;
                    n_bus_held   = 1'b0;
                end
            end
            PH_START_A: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_START_B;
            end
            PH_START_B: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_START_C;
            end
            PH_START_C: begin
                n_tick = w_tick_next;
                if (w_expired) begin
                    n_shift     = {r_addr, r_in_read};
                    n_bit_index = 4'd0;
                    n_phase     = PH_TX_LOW;
                end
            end
            PH_TX_LOW: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                n_tick = w_tick_next;
                if (w_expired) begin
                    n_shift     = {r_shift[6:0], 1'b0};
                    n_bit_index = w_bit_inc;
                    if (w_bit_inc >= 4'd8) begin
                        n_poll  = 8'd0;
                        n_phase = PH_ACK_LOW;
                    end else begin
                        n_phase = PH_TX_LOW;
                    end
                end
            end
            PH_ACK_LOW: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                // The acknowledge is polled every tick while SCL is released.
                n_tick = 16'd0;
                if (!i_item.sda_in) begin
                    n_bit_index = 4'd0;
                    if (r_in_read) begin
                        n_shift = 8'd0;
                        n_phase = PH_RX_LOW;
                    end else if (r_bytes_left != '0) begin
                        n_shift       = i_item.tx_byte;
                        n_res.tx_take = 1'b1;
                        n_bytes_left  = r_bytes_left - i2cm_pkg::t_count'(1);
                        n_phase       = PH_TX_LOW;
                    end else if (r_reads_left != '0) begin
                        n_in_read = 1'b1;
                        n_phase   = PH_RS_A;
                    end else if (r_keep) begin
                        n_bus_held     = 1'b1;
                        n_res.done_res = 1'b1;
                        n_phase        = PH_IDLE;
                    end else begin
                        n_phase = PH_STOP_A;
                    end
                end else begin
                    n_poll = w_poll_inc;
                    if (w_poll_inc >= i_cfg.ack_poll_limit) begin
                        n_fail  = 1'b1;
                        n_phase = PH_STOP_A;
                    end
                end
            end
            PH_RS_A: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_START_A;
            end
            PH_RX_LOW: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
                n_tick = w_tick_next;
                if (w_expired) begin
                    n_shift     = w_rx_shift;
                    n_bit_index = w_bit_inc;
                    if (w_bit_inc >= 4'd8) begin
                        n_res.rx_byte  = w_rx_shift;
                        n_res.rx_valid = 1'b1;
                        n_res.rx_last  = (r_reads_left == i2cm_pkg::t_count'(1));
                        n_phase        = PH_MACK_LOW;
                    end else begin
                        n_phase = PH_RX_LOW;
                    end
                end
            end
            PH_MACK_LOW: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
                n_tick = w_tick_next;
                if (w_expired) begin
                    n_reads_left = r_reads_left - i2cm_pkg::t_count'(1);
                    if (r_reads_left != i2cm_pkg::t_count'(1)) begin
                        n_bit_index = 4'd0;
                        n_shift     = 8'd0;
                        n_phase     = PH_RX_LOW;
                    end else begin
                        n_phase = PH_STOP_A;
                    end
                end
            end
            PH_STOP_A: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_STOP_B;
            end
            PH_STOP_B: begin
                n_tick = w_tick_next;
                if (w_expired) n_phase = PH_STOP_C;
            end
            PH_STOP_C: begin
                n_tick = w_tick_next;
                if (w_expired) begin
                    n_res.done_res = 1'b1;
                    n_res.failed   = r_fail;
                    n_phase        = PH_IDLE;
                end
            end
            default: begin
                n_tick  = 16'd0;
                n_phase = PH_IDLE;
            end
        endcase

        // Pin levels follow the phase that this tick ends in.
        w_last_read = (n_reads_left == i2cm_pkg::t_count'(1));
        case (n_phase)
            PH_IDLE:      begin n_res.scl_release = ~n_bus_held; n_res.sda_release = 1'b1; end
            PH_START_A:   begin n_res.scl_release = 1'b1; n_res.sda_release = 1'b1; end
            PH_START_B:   begin n_res.scl_release = 1'b1; n_res.sda_release = 1'b0; end
            PH_START_C:   begin n_res.scl_release = 1'b0; n_res.sda_release = 1'b0; end
            PH_TX_LOW:    begin n_res.scl_release = 1'b0; n_res.sda_release = n_shift[7]; end
            PH_TX_HIGH:   begin n_res.scl_release = 1'b1; n_res.sda_release = n_shift[7]; end
            PH_ACK_LOW:   begin n_res.scl_release = 1'b0; n_res.sda_release = 1'b1; end
            PH_ACK_HIGH:  begin n_res.scl_release = 1'b1; n_res.sda_release = 1'b1; end
            PH_RS_A:      begin n_res.scl_release = 1'b0; n_res.sda_release = 1'b1; end
            PH_RX_LOW:    begin n_res.scl_release = 1'b0; n_res.sda_release = 1'b1; end
            PH_RX_HIGH:   begin n_res.scl_release = 1'b1; n_res.sda_release = 1'b1; end
            PH_MACK_LOW:  begin n_res.scl_release = 1'b0; n_res.sda_release = w_last_read; end
            PH_MACK_HIGH: begin n_res.scl_release = 1'b1; n_res.sda_release = w_last_read; end
            PH_STOP_A:    begin n_res.scl_release = 1'b0; n_res.sda_release = 1'b0; end
            PH_STOP_B:    begin n_res.scl_release = 1'b1; n_res.sda_release = 1'b0; end
            default:      begin n_res.scl_release = 1'b1; n_res.sda_release = 1'b1; end
        endcase
        n_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= 16'd0;
            r_bit_index  <= 4'd0;
            r_bytes_left <= '0;
            r_reads_left <= '0;
            r_shift      <= 8'd0;
            r_poll       <= 8'd0;
            r_addr       <= 7'd0;
            r_keep       <= 1'b0;
            r_in_read    <= 1'b0;
            r_fail       <= 1'b0;
            r_bus_held   <= 1'b0;
            r_res        <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit_index  <= n_bit_index;
            r_bytes_left <= n_bytes_left;
            r_reads_left <= n_reads_left;
            r_shift      <= n_shift;
            r_poll       <= n_poll;
            r_addr       <= n_addr;
            r_keep       <= n_keep;
            r_in_read    <= n_in_read;
            r_fail       <= n_fail;
            r_bus_held   <= n_bus_held;
            r_res        <= n_res;
        end
    end

    assign o_res = r_res;

    // A failure is only ever reported together with the end of a transaction.
    a_fail_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.failed |-> r_res.done_res && !r_res.busy_res)
        else $error("failure reported without transaction end");

    // A fetched transmit byte always starts a new data bit.
    a_take_enters_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.tx_take |-> (r_phase == PH_TX_LOW) && (r_bit_index == 4'd0))
        else $error("tx byte taken outside a fresh transmit byte");

    // A received byte is followed by the master acknowledge clock.
    a_rx_enters_mack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.rx_valid |-> (r_phase == PH_MACK_LOW) && (r_bit_index == 4'd8))
        else $error("rx byte delivered outside master acknowledge");

    // Without a request the idle sequencer stays idle.
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_phase == PH_IDLE) && !i_item.req_start) |=> (r_phase == PH_IDLE))
        else $error("sequencer left idle without a request");

endmodule

// ===== src/i2c_master_transaction_engine_top.sv =====
// Top level of the I2C master transaction engine: request handshakes and configuration.
// Depends on i2cm_pkg and i2cm_seq.
`timescale 1ns / 1ps

// Usage:
// Each request on the input channel is one bus timing tick. It carries the sampled
// SDA level, the transaction request fields (start, address, counts, keep-bus) and
// the next byte to transmit. For every accepted request the block delivers exactly
// one result request on the output channel: the SCL and SDA release levels after
// that tick, the tx_take, received-byte, done, failure and busy flags.
// Both channels use valid and stall; a request moves at a clock edge with valid high
// and stall low. A result appears in the cycle after its request is accepted; while the
// receiver does not stall, a new request can be accepted every cycle, so the sustained
// rate is one tick per clock. o_out_data comes from a single register stage. When the
// receiver stalls, the result register holds its value and the input stall follows the
// output stall only while a result is waiting, so no result is lost. The user must write
// configuration (half period, acknowledge poll limit) through i_cfg_we, i_cfg_index and
// i_cfg_data only while the engine is idle, which the block does not enforce. The
// synchronous, active-low reset returns the sequencer to idle with no bus held, empties
// the result register and restores the default half period of 50 and poll limit of 11.

module i2c_master_transaction_engine_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  i2cm_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output i2cm_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data
);

    i2cm_pkg::t_cfg r_cfg;
    logic           r_out_valid;
    logic           w_in_accept;

    // The sequencer steps once per accepted tick; the next tick may enter while the
    // previous result is being taken.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_in_accept = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= 16'd50;
            r_cfg.ack_poll_limit    <= 8'd11;
        end else if (i_cfg_we) begin
            case (i2cm_pkg::t_cfg_index'(i_cfg_index))
                i2cm_pkg::CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data;
                i2cm_pkg::CFG_ACK_POLL:    r_cfg.ack_poll_limit    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_in_accept),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_res   (o_out_data)
    );

endmodule
